// ===== src/holonomic_drive_mixer_core_macros.svh =====
// Assertion macros shared by the checker of the holonomic drive mixer.
`ifndef HOLONOMIC_DRIVE_MIXER_CORE_MACROS_SVH
`define HOLONOMIC_DRIVE_MIXER_CORE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define HDM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("holonomic drive mixer assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define HDM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("holonomic drive mixer assertion failed");

`endif

// ===== src/hdm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Holonomic drive mixer package
// Field widths, fixed-point constants, register codes and stage structures.
// ----------------------------------------------------------------------------
package hdm_pkg;

   localparam int ANGLE_W    = 15;
   localparam int MAG_W      = 16;
   localparam int YAW_W      = 16;
   localparam int MODE_W     = 3;
   localparam int WHEEL_W    = 16;
   localparam int MSG_W      = 16;
   localparam int TS_W       = 16;
   localparam int RPM_W      = 10;
   localparam int MSCALE_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int ZW     = 32;
   localparam int XW     = 33;
   localparam int DEN_W  = 33;
   localparam int NUM_W  = 48;
   localparam int QUO_W  = 17;
   localparam int ATAN_LEN = 24;

   localparam logic signed [ZW-1:0] PI_Q28      = 32'sd843314857;
   localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;

   localparam logic signed [ZW-1:0] ATAN_Q28 [ATAN_LEN] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
      32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
      32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
      32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
      32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
      32'sd256,       32'sd128,       32'sd64,       32'sd32
   };

   localparam logic [TS_W-1:0]     TURN_SCALE_RESET    = 16'd39322;
   localparam logic [RPM_W-1:0]    RPM_SCALE_RESET     = 10'd200;
   localparam logic [MSCALE_W-1:0] MESSAGE_SCALE_RESET = 8'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TURN_SCALE    = 2'd0,
      CSR_RPM_SCALE     = 2'd1,
      CSR_MESSAGE_SCALE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                     valid;
      logic                     zero_den;
      logic signed [MAG_W-1:0]  mag;
      logic signed [YAW_W-1:0]  yaw;
      logic [MODE_W-1:0]        mode;
      logic signed [XW-1:0]     sin_v;
      logic signed [XW-1:0]     cos_v;
      logic [QUO_W-1:0]         disp;
      logic [QUO_W-1:0]         turn;
   } mix_in_type;

   typedef struct packed {
      logic                      valid;
      logic signed [WHEEL_W-1:0] wheel_one;
      logic signed [WHEEL_W-1:0] wheel_two;
      logic signed [WHEEL_W-1:0] wheel_three;
      logic signed [WHEEL_W-1:0] wheel_four;
      logic [MSG_W-1:0]          message_word;
      logic [MODE_W-1:0]         message_mode;
   } mix_out_type;

   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== src/hdm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Holonomic drive mixer channels
// Valid/ready channels for command words and wheel result words.
// ----------------------------------------------------------------------------
interface hdm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [hdm_pkg::ANGLE_W-1:0]   drive_angle;
   logic signed [hdm_pkg::MAG_W-1:0]     drive_magnitude;
   logic signed [hdm_pkg::YAW_W-1:0]     yaw_command;
   logic [hdm_pkg::MODE_W-1:0]           chassis_mode;

   modport source(output valid, drive_angle, drive_magnitude, yaw_command, chassis_mode,
                  input ready);
   modport sink(input valid, drive_angle, drive_magnitude, yaw_command, chassis_mode,
                output ready);
endinterface

interface hdm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [hdm_pkg::WHEEL_W-1:0]   wheel_one_rpm;
   logic signed [hdm_pkg::WHEEL_W-1:0]   wheel_two_rpm;
   logic signed [hdm_pkg::WHEEL_W-1:0]   wheel_three_rpm;
   logic signed [hdm_pkg::WHEEL_W-1:0]   wheel_four_rpm;
   logic [hdm_pkg::MSG_W-1:0]            message_word;
   logic [hdm_pkg::MODE_W-1:0]           message_mode;

   modport source(output valid, wheel_one_rpm, wheel_two_rpm, wheel_three_rpm,
                  wheel_four_rpm, message_word, message_mode, input ready);
   modport sink(input valid, wheel_one_rpm, wheel_two_rpm, wheel_three_rpm,
                wheel_four_rpm, message_word, message_mode, output ready);
endinterface

// ===== src/holonomic_drive_mixer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Holonomic drive mixer core
// Each word passes the front register, the sine/cosine and divider pipelines and
// mixer stages A to D, one word per cycle unless stalled; those pipelines set
// the depth, the 17 quotient bits of the weight dividers being one per stage.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Synchronous reset empties the pipeline and restores the register defaults.
// ----------------------------------------------------------------------------
module holonomic_drive_mixer_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   hdm_req_if.sink                           req_chan,
   hdm_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [hdm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hdm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import hdm_pkg::*;

   localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
   localparam int PIPE  = (STEPS > QUO_W) ? STEPS : QUO_W;

   logic [TS_W-1:0]     turn_scale_ff;
   logic [RPM_W-1:0]    rpm_scale_ff;
   logic [MSCALE_W-1:0] message_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_scale_ff    <= TURN_SCALE_RESET;
         rpm_scale_ff     <= RPM_SCALE_RESET;
         message_scale_ff <= MESSAGE_SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TURN_SCALE:    turn_scale_ff    <= csr_data[TS_W-1:0];
            CSR_RPM_SCALE:     rpm_scale_ff     <= csr_data[RPM_W-1:0];
            CSR_MESSAGE_SCALE: message_scale_ff <= csr_data[MSCALE_W-1:0];
            default: ;
         endcase
      end
   end

   mix_out_type mix_out;
   logic        en;

   assign en             = !mix_out.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   // Front stage: angle reduction, absolute values and weight operands.
   logic signed [ZW-1:0] z_ff, z_in;
   logic                 neg_ff, neg_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [NUM_W-1:0]     numd_ff, numd_in, numt_ff, numt_in;
   logic signed [MAG_W-1:0] mag_ff;
   logic signed [YAW_W-1:0] yaw_ff;
   logic [MODE_W-1:0]    mode_ff;
   logic                 vld_ff;

   always_comb begin
      logic signed [ZW-1:0] z0;
      logic [MAG_W-1:0]     am, ay;
      logic [31:0]          tpart;
      z0 = ZW'(req_chan.drive_angle) <<< 16;
      if (z0 > HALF_PI_Q28) begin
         z_in   = z0 - PI_Q28;
         neg_in = 1'b1;
      end else if (z0 < -HALF_PI_Q28) begin
         z_in   = z0 + PI_Q28;
         neg_in = 1'b1;
      end else begin
         z_in   = z0;
         neg_in = 1'b0;
      end
      am      = req_chan.drive_magnitude[MAG_W-1] ? MAG_W'(-req_chan.drive_magnitude)
                                                  : MAG_W'(req_chan.drive_magnitude);
      ay      = req_chan.yaw_command[YAW_W-1] ? YAW_W'(-req_chan.yaw_command)
                                              : YAW_W'(req_chan.yaw_command);
      tpart   = turn_scale_ff * ay;
      den_in  = DEN_W'({am, 16'b0}) + DEN_W'(tpart);
      numd_in = {am, 32'b0};
      numt_in = {tpart, 16'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff    <= z_in;
         neg_ff  <= neg_in;
         den_ff  <= den_in;
         numd_ff <= numd_in;
         numt_ff <= numt_in;
         mag_ff  <= req_chan.drive_magnitude;
         yaw_ff  <= req_chan.yaw_command;
         mode_ff <= req_chan.chassis_mode;
      end
   end

   logic signed [XW-1:0] sin_v, cos_v;
   logic [QUO_W-1:0]     disp_q, turn_q;

   hdm_cordic #(.STEPS(STEPS), .STAGES(PIPE)) u_cordic (
      .clock   (clock),
      .en      (en),
      .z_in    (z_ff),
      .neg_in  (neg_ff),
      .sin_out (sin_v),
      .cos_out (cos_v)
   );

   hdm_divider #(.STAGES(PIPE)) u_div_disp (
      .clock   (clock),
      .en      (en),
      .num_in  (numd_ff),
      .den_in  (den_ff),
      .quo_out (disp_q)
   );

   hdm_divider #(.STAGES(PIPE)) u_div_turn (
      .clock   (clock),
      .en      (en),
      .num_in  (numt_ff),
      .den_in  (den_ff),
      .quo_out (turn_q)
   );

   // Side data travels alongside the shared pipelines.
   logic                    vld_d_ff  [PIPE];
   logic                    zero_d_ff [PIPE];
   logic signed [MAG_W-1:0] mag_d_ff  [PIPE];
   logic signed [YAW_W-1:0] yaw_d_ff  [PIPE];
   logic [MODE_W-1:0]       mode_d_ff [PIPE];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE; i++) begin
            vld_d_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_d_ff[0] <= vld_ff;
         for (int i = 1; i < PIPE; i++) begin
            vld_d_ff[i] <= vld_d_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_d_ff[0] <= (den_ff == '0);
         mag_d_ff[0]  <= mag_ff;
         yaw_d_ff[0]  <= yaw_ff;
         mode_d_ff[0] <= mode_ff;
         for (int i = 1; i < PIPE; i++) begin
            zero_d_ff[i] <= zero_d_ff[i-1];
            mag_d_ff[i]  <= mag_d_ff[i-1];
            yaw_d_ff[i]  <= yaw_d_ff[i-1];
            mode_d_ff[i] <= mode_d_ff[i-1];
         end
      end
   end

   mix_in_type mix_in;

   always_comb begin
      mix_in.valid    = vld_d_ff[PIPE-1];
      mix_in.zero_den = zero_d_ff[PIPE-1];
      mix_in.mag      = mag_d_ff[PIPE-1];
      mix_in.yaw      = yaw_d_ff[PIPE-1];
      mix_in.mode     = mode_d_ff[PIPE-1];
      mix_in.sin_v    = sin_v;
      mix_in.cos_v    = cos_v;
      mix_in.disp     = disp_q;
      mix_in.turn     = turn_q;
   end

   hdm_mixer u_mixer (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .rpm_scale     (rpm_scale_ff),
      .message_scale (message_scale_ff),
      .mix_in        (mix_in),
      .mix_out       (mix_out)
   );

   assign rsp_chan.valid           = mix_out.valid;
   assign rsp_chan.wheel_one_rpm   = mix_out.wheel_one;
   assign rsp_chan.wheel_two_rpm   = mix_out.wheel_two;
   assign rsp_chan.wheel_three_rpm = mix_out.wheel_three;
   assign rsp_chan.wheel_four_rpm  = mix_out.wheel_four;
   assign rsp_chan.message_word    = mix_out.message_word;
   assign rsp_chan.message_mode    = mix_out.message_mode;

endmodule

// ===== src/hdm_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// One rotation step per stage; later stages only carry the vector along.
// ----------------------------------------------------------------------------
module hdm_cordic #(
   parameter int STEPS  = 16,
   parameter int STAGES = 17
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [hdm_pkg::ZW-1:0] z_in,
   input  logic                         neg_in,
   output logic signed [hdm_pkg::XW-1:0] sin_out,
   output logic signed [hdm_pkg::XW-1:0] cos_out
);
   import hdm_pkg::*;

   logic signed [XW-1:0] x_ff [STAGES];
   logic signed [XW-1:0] y_ff [STAGES];
   logic signed [ZW-1:0] z_ff [STAGES];
   logic                 neg_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [XW-1:0] x_prev, y_prev, x_in, y_in;
      logic signed [ZW-1:0] z_prev, z_in_s;
      logic                 neg_prev;

      if (i == 0) begin : g_first
         assign x_prev   = GAIN_Q30;
         assign y_prev   = '0;
         assign z_prev   = z_in;
         assign neg_prev = neg_in;
      end else begin : g_next
         assign x_prev   = x_ff[i-1];
         assign y_prev   = y_ff[i-1];
         assign z_prev   = z_ff[i-1];
         assign neg_prev = neg_ff[i-1];
      end

      if (i < STEPS) begin : g_rot
         always_comb begin
            if (z_prev >= 0) begin
               x_in   = x_prev - (y_prev >>> i);
               y_in   = y_prev + (x_prev >>> i);
               z_in_s = z_prev - ATAN_Q28[i];
            end else begin
               x_in   = x_prev + (y_prev >>> i);
               y_in   = y_prev - (x_prev >>> i);
               z_in_s = z_prev + ATAN_Q28[i];
            end
         end
      end else begin : g_hold
         assign x_in   = x_prev;
         assign y_in   = y_prev;
         assign z_in_s = z_prev;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            z_ff[i]   <= z_in_s;
            neg_ff[i] <= neg_prev;
         end
      end
   end

   assign sin_out = neg_ff[STAGES-1] ? -y_ff[STAGES-1] : y_ff[STAGES-1];
   assign cos_out = neg_ff[STAGES-1] ? -x_ff[STAGES-1] : x_ff[STAGES-1];

endmodule

// ===== src/hdm_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; later stages only carry the quotient along.
// ----------------------------------------------------------------------------
module hdm_divider #(
   parameter int STAGES = 17
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [hdm_pkg::NUM_W-1:0]     num_in,
   input  logic [hdm_pkg::DEN_W-1:0]     den_in,
   output logic [hdm_pkg::QUO_W-1:0]     quo_out
);
   import hdm_pkg::*;

   logic [DEN_W-1:0] rem_ff [STAGES];
   logic [NUM_W-1:0] num_ff [STAGES];
   logic [DEN_W-1:0] den_ff [STAGES];
   logic [QUO_W-1:0] quo_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic [DEN_W-1:0] rem_prev, rem_in, den_prev;
      logic [NUM_W-1:0] num_prev;
      logic [QUO_W-1:0] quo_prev, quo_in;

      if (i == 0) begin : g_first
         assign rem_prev = DEN_W'(num_in >> QUO_W);
         assign num_prev = num_in;
         assign den_prev = den_in;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign num_prev = num_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      if (i < QUO_W) begin : g_bit
         logic [DEN_W:0] trial;
         always_comb begin
            trial  = {rem_prev, num_prev[QUO_W-1-i]};
            quo_in = quo_prev;
            if (trial >= {1'b0, den_prev}) begin
               rem_in = DEN_W'(trial - {1'b0, den_prev});
               quo_in[QUO_W-1-i] = 1'b1;
            end else begin
               rem_in = trial[DEN_W-1:0];
            end
         end
      end else begin : g_hold
         assign rem_in = rem_prev;
         assign quo_in = quo_prev;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            num_ff[i] <= num_prev;
            den_ff[i] <= den_prev;
            quo_ff[i] <= quo_in;
         end
      end
   end

   assign quo_out = quo_ff[STAGES-1];

endmodule

// ===== src/hdm_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel mixer stages
// Displacement terms, yaw mix, rpm scaling, saturation and message packing.
// ----------------------------------------------------------------------------
module hdm_mixer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [hdm_pkg::RPM_W-1:0]     rpm_scale,
   input  logic [hdm_pkg::MSCALE_W-1:0]  message_scale,
   input  hdm_pkg::mix_in_type           mix_in,
   output hdm_pkg::mix_out_type          mix_out
);
   import hdm_pkg::*;

   localparam int DW  = XW + 3;
   localparam int TYW = QUO_W + YAW_W + 1;
   localparam int PW  = 55;
   localparam int WW  = 40;
   localparam int MW  = WW + MSCALE_W + 1;

   // Stage A
   logic                 a_vld_ff;
   logic signed [DW-1:0] a_d1_ff, a_d2_ff, a_d1_in, a_d2_in;
   logic signed [TYW-1:0] a_ty_ff, a_ty_in;
   logic [QUO_W-1:0]     a_disp_ff, a_disp_in, turn_v;
   logic [MODE_W-1:0]    a_mode_ff;

   always_comb begin
      logic signed [XW:0]        diff, sum;
      logic signed [XW+MAG_W:0]  pd1, pd2;
      diff      = (XW+1)'(mix_in.sin_v) - (XW+1)'(mix_in.cos_v);
      sum       = (XW+1)'(mix_in.cos_v) + (XW+1)'(mix_in.sin_v);
      pd1       = (XW+MAG_W+1)'(mix_in.mag) * (XW+MAG_W+1)'(diff);
      pd2       = (XW+MAG_W+1)'(mix_in.mag) * (XW+MAG_W+1)'(sum);
      a_d1_in   = DW'(pd1 >>> 14);
      a_d2_in   = DW'(pd2 >>> 14);
      a_disp_in = mix_in.zero_den ? '0 : mix_in.disp;
      turn_v    = mix_in.zero_den ? '0 : mix_in.turn;
      a_ty_in   = $signed({1'b0, turn_v}) * mix_in.yaw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= mix_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_d1_ff   <= a_d1_in;
         a_d2_ff   <= a_d2_in;
         a_ty_ff   <= a_ty_in;
         a_disp_ff <= a_disp_in;
         a_mode_ff <= mix_in.mode;
      end
   end

   // Stage B
   logic                 b_vld_ff;
   logic signed [PW-1:0] b_p_ff [4];
   logic signed [PW-1:0] b_p_in [4];
   logic [MODE_W-1:0]    b_mode_ff;

   always_comb begin
      logic signed [PW-1:0] m1, m2, tys;
      m1  = PW'($signed({1'b0, a_disp_ff}) * a_d1_ff);
      m2  = PW'($signed({1'b0, a_disp_ff}) * a_d2_ff);
      tys = PW'(a_ty_ff) <<< 16;
      b_p_in[0] = tys + m1;
      b_p_in[1] = tys + m2;
      b_p_in[2] = tys - m1;
      b_p_in[3] = tys - m2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_p_ff    <= b_p_in;
         b_mode_ff <= a_mode_ff;
      end
   end

   // Stage C
   logic                 c_vld_ff;
   logic signed [WW-1:0] c_w_ff [4];
   logic signed [WW-1:0] c_w_in [4];
   logic [MODE_W-1:0]    c_mode_ff;

   always_comb begin
      logic signed [PW+RPM_W:0] prod;
      for (int k = 0; k < 4; k++) begin
         prod      = (PW+RPM_W+1)'(b_p_ff[k]) * $signed({1'b0, rpm_scale});
         c_w_in[k] = WW'(prod >>> 26);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_w_ff    <= c_w_in;
         c_mode_ff <= b_mode_ff;
      end
   end

   // Stage D: output register
   logic signed [WHEEL_W-1:0] d_wheel_in [4];
   logic [MSG_W-1:0]          d_msg_in;
   mix_out_type               out_ff;

   always_comb begin
      logic signed [WW-1:0] rnd;
      logic signed [MW-1:0] msg;
      logic [MW-1:0]        msg_abs;
      logic signed [31:0]   msg_q;
      logic signed [15:0]   msg_sat;
      for (int k = 0; k < 4; k++) begin
         rnd           = c_w_ff[k] + WW'(32768);
         d_wheel_in[k] = sat16(32'(rnd >>> 16));
      end
      msg     = MW'(c_w_ff[0]) * $signed({1'b0, message_scale});
      msg_abs = msg[MW-1] ? MW'(-msg) : MW'(msg);
      msg_q   = 32'(msg_abs >> 20);
      if (msg[MW-1]) begin
         msg_q = -msg_q;
      end
      msg_sat  = sat16(msg_q);
      d_msg_in = {~msg_sat[15], msg_sat[14:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= c_vld_ff;
      end
      if (en) begin
         out_ff.wheel_one    <= d_wheel_in[0];
         out_ff.wheel_two    <= d_wheel_in[1];
         out_ff.wheel_three  <= d_wheel_in[2];
         out_ff.wheel_four   <= d_wheel_in[3];
         out_ff.message_word <= d_msg_in;
         out_ff.message_mode <= c_mode_ff;
      end
   end

   assign mix_out = out_ff;

endmodule

// ===== src/hdm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Holonomic drive mixer port checker
// Watches the top-level handshakes and the stall behavior of the pipeline.
// ----------------------------------------------------------------------------
`include "holonomic_drive_mixer_core_macros.svh"

module hdm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [hdm_pkg::WHEEL_W-1:0] wheel_one_rpm,
   input logic [hdm_pkg::MSG_W-1:0]          message_word
);
   import hdm_pkg::*;

   `HDM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `HDM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(wheel_one_rpm) && $stable(message_word))
   `HDM_ASSERT_SAME(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `HDM_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

endmodule

bind holonomic_drive_mixer_core hdm_checker u_hdm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .wheel_one_rpm (rsp_chan.wheel_one_rpm),
   .message_word  (rsp_chan.message_word)
);
